### rtl/frc_pkg.sv
// Shared types, constants and the arctangent table of the fisheye remap coordinate block
package frc_pkg;

	// field and register widths
	localparam int IN_W  = 12;
	localparam int OUT_W = 12;
	localparam int CFG_W = 13;

	// defaults of the top-level parameters
	localparam int DEF_MAX_DIM         = 4096;
	localparam int DEF_ANGLE_FRAC_BITS = 16;

	// image size after reset
	localparam logic [CFG_W-1:0] DIM_RESET = 13'd620;

	// CORDIC gain in Q30
	localparam int              GAIN_FRAC       = 30;
	localparam logic [29:0]     CORDIC_GAIN_Q30 = 30'd652032874;

	// configuration register indexes; other index values are ignored
	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	// input transaction
	typedef struct packed {
		logic [IN_W-1:0] out_x;
		logic [IN_W-1:0] out_y;
	} item_t;

	// result transaction
	typedef struct packed {
		logic [OUT_W-1:0] src_x;
		logic [OUT_W-1:0] src_y;
		logic             in_range;
	} result_t;

	// atan(2^-i) where one full turn is 2^32
	function automatic logic [31:0] atan_turn32(input int idx);
		logic [31:0] v;
		case (idx)
			0:  v = 32'h20000000;
			1:  v = 32'h12E4051D;
			2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4;
			4:  v = 32'h028B0D43;
			5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E;
			7:  v = 32'h00517C55;
			8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2E;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2F9;
			15: v = 32'h0000517C;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A2F;
			19: v = 32'h00000517;
			20: v = 32'h0000028B;
			21: v = 32'h00000145;
			22: v = 32'h000000A2;
			23: v = 32'h00000051;
			24: v = 32'h00000028;
			25: v = 32'h00000014;
			26: v = 32'h0000000A;
			27: v = 32'h00000005;
			28: v = 32'h00000002;
			29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

### rtl/frc_div_cell.sv
// One restoring division step: brings down a dividend bit and emits one quotient bit
module frc_div_cell #(
	parameter int DW = 13,
	parameter int QB = 17
) (
	input  logic                       clk,
	input  logic [DW-1:0]              divisor,
	input  logic [frc_pkg::IN_W-1:0]   num_in,
	input  logic [DW-1:0]              rem_in,
	input  logic [QB-1:0]              quo_in,
	output logic [frc_pkg::IN_W-1:0]   num_s1,
	output logic [DW-1:0]              rem_s1,
	output logic [QB-1:0]              quo_s1
);
	import frc_pkg::*;

	logic [DW:0] part;
	logic [DW:0] diff;
	logic        take;

	// partial remainder with the next dividend bit appended
	assign part = {rem_in, num_in[IN_W-1]};
	assign diff = part - {1'b0, divisor};
	assign take = (part >= {1'b0, divisor});

	// hand on to the next cell; zeros follow the integer bits
	always_ff @(posedge clk) begin
		num_s1 <= {num_in[IN_W-2:0], 1'b0};
		rem_s1 <= take ? diff[DW-1:0] : part[DW-1:0];
		quo_s1 <= {quo_in[QB-2:0], take};
	end

endmodule

### rtl/frc_rot_cell.sv
// One CORDIC rotation micro-rotation, steered by the sign of the residual angle
module frc_rot_cell #(
	parameter int XW  = 19,
	parameter int ZW  = 19,
	parameter int AFB = 16,
	parameter int I   = 0,
	parameter int SW  = 1
) (
	input  logic                 clk,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic [SW-1:0]        side_in,
	output logic signed [XW-1:0] x_s1,
	output logic signed [XW-1:0] y_s1,
	output logic signed [ZW-1:0] z_s1,
	output logic [SW-1:0]        side_s1
);
	import frc_pkg::*;

	localparam logic signed [ZW-1:0] STEP = ZW'(atan_turn32(I) >> (31 - AFB));

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign dx = y_in >>> I;
	assign dy = x_in >>> I;

	// rotate towards zero residual angle
	always_ff @(posedge clk) begin
		if (!z_in[ZW-1]) begin
			x_s1 <= x_in - dx;
			y_s1 <= y_in + dy;
			z_s1 <= z_in - STEP;
		end else begin
			x_s1 <= x_in + dx;
			y_s1 <= y_in - dy;
			z_s1 <= z_in + STEP;
		end
		side_s1 <= side_in;
	end

endmodule

### rtl/frc_vec_cell.sv
// One CORDIC vectoring micro-rotation, driving y towards zero
module frc_vec_cell #(
	parameter int VW  = 20,
	parameter int ZW  = 19,
	parameter int AFB = 16,
	parameter int I   = 0,
	parameter int SW  = 1
) (
	input  logic                 clk,
	input  logic signed [VW-1:0] x_in,
	input  logic signed [VW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  logic [SW-1:0]        side_in,
	output logic signed [VW-1:0] x_s1,
	output logic signed [VW-1:0] y_s1,
	output logic signed [ZW-1:0] z_s1,
	output logic [SW-1:0]        side_s1
);
	import frc_pkg::*;

	localparam logic signed [ZW-1:0] STEP = ZW'(atan_turn32(I) >> (31 - AFB));

	logic signed [VW-1:0] dx;
	logic signed [VW-1:0] dy;

	assign dx = y_in >>> I;
	assign dy = x_in >>> I;

	// accumulate the angle while rotating the vector onto the x axis
	always_ff @(posedge clk) begin
		if (y_in > 0) begin
			x_s1 <= x_in + dx;
			y_s1 <= y_in - dy;
			z_s1 <= z_in + STEP;
		end else begin
			x_s1 <= x_in - dx;
			y_s1 <= y_in + dy;
			z_s1 <= z_in - STEP;
		end
		side_s1 <= side_in;
	end

endmodule

### rtl/fisheye_remap_coordinate.sv
// Top level of the fisheye remap coordinate block: divider, CORDIC cell chains and output stage
// Throughput: one transaction per clock; busy is never raised and done is a one-cycle strobe.
// The latency is set by the cell chains: 12 + ANGLE_FRAC_BITS divider cells, then three
// CORDIC chains of ANGLE_FRAC_BITS cells each, plus ten single register stages.
// Reset clears the valid pipeline and sets both size registers to 620; no clearing pass.
module fisheye_remap_coordinate #(
	parameter int MAX_DIM         = frc_pkg::DEF_MAX_DIM,
	parameter int ANGLE_FRAC_BITS = frc_pkg::DEF_ANGLE_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  frc_pkg::item_t           item,
	output logic                     done,
	output frc_pkg::result_t         result,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  frc_pkg::cfg_reg_t        cfg_index,
	input  logic [frc_pkg::CFG_W-1:0] cfg_data
);
	import frc_pkg::*;

	localparam int AFB  = ANGLE_FRAC_BITS;
	localparam int DW   = $clog2(MAX_DIM) + 1;
	localparam int QB   = AFB + 1;
	localparam int NDIV = IN_W + AFB;
	localparam int XW   = AFB + 3;
	localparam int ZW   = AFB + 3;
	localparam int VW   = AFB + 4;
	localparam int PW   = ZW + XW - AFB;
	localparam int QW   = DW + PW + 2;
	localparam int TW   = QW - AFB;
	localparam int LAT  = NDIV + 3 * AFB + 10;

	localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(1) << AFB;
	localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(1) << (AFB - 1);
	localparam logic [QB-1:0]        QUARTER_Q    = QB'(1) << (AFB - 1);
	localparam logic signed [XW-1:0] X_INIT       = XW'(CORDIC_GAIN_Q30 >> (GAIN_FRAC - AFB));

	// zero reads as one, oversize saturates
	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		if (v == '0)
			return DW'(1);
		else if (32'(v) > MAX_DIM)
			return DW'(MAX_DIM);
		else
			return DW'(v);
	endfunction

	// fold an angle into [-pi/2, pi/2]; top bit flags a negation of the results
	function automatic logic [ZW:0] fold_angle(input logic signed [ZW-1:0] z);
		if (z > QUARTER_TURN)
			return {1'b1, z - HALF_TURN};
		else if (z < -QUARTER_TURN)
			return {1'b1, z + HALF_TURN};
		else
			return {1'b0, z};
	endfunction

	// ---------------- configuration ----------------
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [DW-1:0]    dim_w;
	logic [DW-1:0]    dim_h;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dim_w = clamp_dim(width_q);
	assign dim_h = clamp_dim(height_q);

	// ---------------- valid pipeline ----------------
	logic [LAT-1:0] vld_q;
	logic           accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[LAT-2:0], accept};
	end

	assign done = vld_q[LAT-1];

	// ---------------- divider chains: v * 2^F / dim ----------------
	logic [IN_W-1:0] xn [NDIV+1];
	logic [DW-1:0]   xr [NDIV+1];
	logic [QB-1:0]   xq [NDIV+1];
	logic [IN_W-1:0] yn [NDIV+1];
	logic [DW-1:0]   yr [NDIV+1];
	logic [QB-1:0]   yq [NDIV+1];

	assign xn[0] = item.out_x;
	assign xr[0] = '0;
	assign xq[0] = '0;
	assign yn[0] = item.out_y;
	assign yr[0] = '0;
	assign yq[0] = '0;

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		frc_div_cell #(.DW(DW), .QB(QB)) u_div_x (
			.clk, .divisor(dim_w),
			.num_in(xn[k]), .rem_in(xr[k]), .quo_in(xq[k]),
			.num_s1(xn[k+1]), .rem_s1(xr[k+1]), .quo_s1(xq[k+1])
		);
		frc_div_cell #(.DW(DW), .QB(QB)) u_div_y (
			.clk, .divisor(dim_h),
			.num_in(yn[k]), .rem_in(yr[k]), .quo_in(yq[k]),
			.num_s1(yn[k+1]), .rem_s1(yr[k+1]), .quo_s1(yq[k+1])
		);
	end

	// ---------------- stage 1: longitude/latitude, wrapped and folded ----------------
	logic signed [AFB:0] lon_w;
	logic signed [AFB:0] lat_w;
	logic signed [ZW-1:0] lon_z_s1;
	logic signed [ZW-1:0] lat_z_s1;
	logic                 lon_neg_s1;
	logic                 lat_neg_s1;

	assign lon_w = signed'(xq[NDIV] - QUARTER_Q);
	assign lat_w = signed'(yq[NDIV] - QUARTER_Q);

	always_ff @(posedge clk) begin
		{lon_neg_s1, lon_z_s1} <= fold_angle(ZW'(lon_w));
		{lat_neg_s1, lat_z_s1} <= fold_angle(ZW'(lat_w));
	end

	// ---------------- rotation chains for lon and lat ----------------
	logic signed [XW-1:0] lnx [AFB+1];
	logic signed [XW-1:0] lny [AFB+1];
	logic signed [ZW-1:0] lnz [AFB+1];
	logic [0:0]           lns [AFB+1];
	logic signed [XW-1:0] ltx [AFB+1];
	logic signed [XW-1:0] lty [AFB+1];
	logic signed [ZW-1:0] ltz [AFB+1];
	logic [0:0]           lts [AFB+1];

	assign lnx[0] = X_INIT;
	assign lny[0] = '0;
	assign lnz[0] = lon_z_s1;
	assign lns[0] = lon_neg_s1;
	assign ltx[0] = X_INIT;
	assign lty[0] = '0;
	assign ltz[0] = lat_z_s1;
	assign lts[0] = lat_neg_s1;

	for (genvar i = 0; i < AFB; i++) begin : g_rot_ll
		frc_rot_cell #(.XW(XW), .ZW(ZW), .AFB(AFB), .I(i), .SW(1)) u_lon (
			.clk, .x_in(lnx[i]), .y_in(lny[i]), .z_in(lnz[i]), .side_in(lns[i]),
			.x_s1(lnx[i+1]), .y_s1(lny[i+1]), .z_s1(lnz[i+1]), .side_s1(lns[i+1])
		);
		frc_rot_cell #(.XW(XW), .ZW(ZW), .AFB(AFB), .I(i), .SW(1)) u_lat (
			.clk, .x_in(ltx[i]), .y_in(lty[i]), .z_in(ltz[i]), .side_in(lts[i]),
			.x_s1(ltx[i+1]), .y_s1(lty[i+1]), .z_s1(ltz[i+1]), .side_s1(lts[i+1])
		);
	end

	// ---------------- stage 2: undo the fold ----------------
	logic signed [XW-1:0] clon_s2;
	logic signed [XW-1:0] slon_s2;
	logic signed [XW-1:0] clat_s2;
	logic signed [XW-1:0] slat_s2;

	always_ff @(posedge clk) begin
		clon_s2 <= lns[AFB][0] ? -lnx[AFB] : lnx[AFB];
		slon_s2 <= lns[AFB][0] ? -lny[AFB] : lny[AFB];
		clat_s2 <= lts[AFB][0] ? -ltx[AFB] : ltx[AFB];
		slat_s2 <= lts[AFB][0] ? -lty[AFB] : lty[AFB];
	end

	// ---------------- stage 3: direction vector ----------------
	logic signed [2*XW-1:0] p_vx;
	logic signed [2*XW-1:0] p_vy;
	logic signed [2*XW-1:0] p_vz;
	logic signed [VW-1:0]   vx_s3;
	logic signed [VW-1:0]   vy_s3;
	logic signed [VW-1:0]   vz_s3;

	assign p_vx = clat_s2 * slon_s2;
	assign p_vy = clat_s2 * clon_s2;
	assign p_vz = slat_s2 * clon_s2;

	always_ff @(posedge clk) begin
		vx_s3 <= VW'(p_vx >>> AFB);
		vy_s3 <= VW'(p_vy >>> AFB);
		vz_s3 <= VW'(p_vz >>> AFB);
	end

	// ---------------- stage 4: fold for the first vectoring ----------------
	logic signed [VW-1:0] v1x_s4;
	logic signed [VW-1:0] v1y_s4;
	logic signed [VW-1:0] vy_s4;
	logic                 v1base_s4;
	logic                 v1zero_s4;

	always_ff @(posedge clk) begin
		v1x_s4    <= vx_s3[VW-1] ? -vx_s3 : vx_s3;
		v1y_s4    <= vx_s3[VW-1] ? -vz_s3 : vz_s3;
		v1base_s4 <= vx_s3[VW-1];
		v1zero_s4 <= (vx_s3 == '0) && (vz_s3 == '0);
		vy_s4     <= vy_s3;
	end

	// ---------------- vectoring chain: a = atan2(Z, X), m = |(X, Z)| ----------------
	localparam int S1W = VW + 2;

	logic signed [VW-1:0] ax [AFB+1];
	logic signed [VW-1:0] ay [AFB+1];
	logic signed [ZW-1:0] az [AFB+1];
	logic [S1W-1:0]       as [AFB+1];

	assign ax[0] = v1x_s4;
	assign ay[0] = v1y_s4;
	assign az[0] = '0;
	assign as[0] = {vy_s4, v1base_s4, v1zero_s4};

	for (genvar i = 0; i < AFB; i++) begin : g_vec_a
		frc_vec_cell #(.VW(VW), .ZW(ZW), .AFB(AFB), .I(i), .SW(S1W)) u_vec (
			.clk, .x_in(ax[i]), .y_in(ay[i]), .z_in(az[i]), .side_in(as[i]),
			.x_s1(ax[i+1]), .y_s1(ay[i+1]), .z_s1(az[i+1]), .side_s1(as[i+1])
		);
	end

	// ---------------- stage 5: angle and gain-corrected magnitude ----------------
	logic signed [VW+GAIN_FRAC:0] m_prod;
	logic signed [ZW-1:0]         a_s5;
	logic signed [VW-1:0]         m_s5;
	logic signed [VW-1:0]         vy_s5;

	assign m_prod = ax[AFB] * $signed({1'b0, CORDIC_GAIN_Q30});

	always_ff @(posedge clk) begin
		a_s5  <= as[AFB][0] ? '0 : ((as[AFB][1] ? HALF_TURN : '0) + az[AFB]);
		m_s5  <= as[AFB][0] ? '0 : VW'(m_prod >>> GAIN_FRAC);
		vy_s5 <= signed'(as[AFB][S1W-1:2]);
	end

	// ---------------- stage 6: folds for second vectoring and rotation by a ----------------
	logic signed [VW-1:0] v2x_s6;
	logic signed [VW-1:0] v2y_s6;
	logic                 v2base_s6;
	logic                 v2zero_s6;
	logic signed [ZW-1:0] a_z_s6;
	logic                 a_neg_s6;

	always_ff @(posedge clk) begin
		v2x_s6    <= vy_s5[VW-1] ? -vy_s5 : vy_s5;
		v2y_s6    <= vy_s5[VW-1] ? -m_s5 : m_s5;
		v2base_s6 <= vy_s5[VW-1];
		v2zero_s6 <= (vy_s5 == '0) && (m_s5 == '0);
		{a_neg_s6, a_z_s6} <= fold_angle(ZW'(signed'(a_s5[AFB:0])));
	end

	// ---------------- vectoring chain for b and rotation chain for cos/sin(a) ----------------
	logic signed [VW-1:0] bx [AFB+1];
	logic signed [VW-1:0] by [AFB+1];
	logic signed [ZW-1:0] bz [AFB+1];
	logic [1:0]           bs [AFB+1];
	logic signed [XW-1:0] rx [AFB+1];
	logic signed [XW-1:0] ry [AFB+1];
	logic signed [ZW-1:0] rz [AFB+1];
	logic [0:0]           rs [AFB+1];

	assign bx[0] = v2x_s6;
	assign by[0] = v2y_s6;
	assign bz[0] = '0;
	assign bs[0] = {v2base_s6, v2zero_s6};
	assign rx[0] = X_INIT;
	assign ry[0] = '0;
	assign rz[0] = a_z_s6;
	assign rs[0] = a_neg_s6;

	for (genvar i = 0; i < AFB; i++) begin : g_vec_b
		frc_vec_cell #(.VW(VW), .ZW(ZW), .AFB(AFB), .I(i), .SW(2)) u_vec (
			.clk, .x_in(bx[i]), .y_in(by[i]), .z_in(bz[i]), .side_in(bs[i]),
			.x_s1(bx[i+1]), .y_s1(by[i+1]), .z_s1(bz[i+1]), .side_s1(bs[i+1])
		);
		frc_rot_cell #(.XW(XW), .ZW(ZW), .AFB(AFB), .I(i), .SW(1)) u_rot (
			.clk, .x_in(rx[i]), .y_in(ry[i]), .z_in(rz[i]), .side_in(rs[i]),
			.x_s1(rx[i+1]), .y_s1(ry[i+1]), .z_s1(rz[i+1]), .side_s1(rs[i+1])
		);
	end

	// ---------------- stage 7: b, cos(a), sin(a) ----------------
	logic signed [ZW-1:0] b_s7;
	logic signed [XW-1:0] ca_s7;
	logic signed [XW-1:0] sa_s7;

	always_ff @(posedge clk) begin
		b_s7  <= bs[AFB][0] ? '0 : ((bs[AFB][1] ? HALF_TURN : '0) + bz[AFB]);
		ca_s7 <= rs[AFB][0] ? -rx[AFB] : rx[AFB];
		sa_s7 <= rs[AFB][0] ? -ry[AFB] : ry[AFB];
	end

	// ---------------- stage 8: radius times direction ----------------
	logic signed [ZW+XW-1:0] p_bx;
	logic signed [ZW+XW-1:0] p_by;
	logic signed [PW-1:0]    pbx_s8;
	logic signed [PW-1:0]    pby_s8;

	assign p_bx = b_s7 * ca_s7;
	assign p_by = b_s7 * sa_s7;

	always_ff @(posedge clk) begin
		pbx_s8 <= PW'(p_bx >>> AFB);
		pby_s8 <= PW'(p_by >>> AFB);
	end

	// ---------------- stage 9: scale to pixels and centre ----------------
	logic signed [QW-1:0]   wq;
	logic signed [QW-1:0]   hq;
	logic signed [DW+PW:0]  sc_x;
	logic signed [DW+PW:0]  sc_y;
	logic signed [QW-1:0]   qx_s9;
	logic signed [QW-1:0]   qy_s9;

	assign wq = QW'($signed({1'b0, dim_w}));
	assign hq = QW'($signed({1'b0, dim_h}));

	// size times offset at its natural width
	assign sc_x = $signed({1'b0, dim_w}) * pbx_s8;
	assign sc_y = $signed({1'b0, dim_h}) * pby_s8;

	always_ff @(posedge clk) begin
		qx_s9 <= QW'(sc_x) + (wq <<< (AFB - 1));
		qy_s9 <= QW'(sc_y) + (hq <<< (AFB - 1));
	end

	// ---------------- stage 10: truncate toward zero and range check ----------------
	logic [QW-1:0] mag_x;
	logic [QW-1:0] mag_y;
	logic [TW-1:0] tx;
	logic [TW-1:0] ty;
	logic          ok_x;
	logic          ok_y;
	result_t       res_s10;

	assign mag_x = qx_s9[QW-1] ? QW'(-qx_s9) : QW'(qx_s9);
	assign mag_y = qy_s9[QW-1] ? QW'(-qy_s9) : QW'(qy_s9);
	assign tx    = TW'(mag_x >> AFB);
	assign ty    = TW'(mag_y >> AFB);
	// a small negative value truncates to zero and still counts as inside
	assign ok_x  = qx_s9[QW-1] ? (tx == '0) : (tx < TW'(dim_w));
	assign ok_y  = qy_s9[QW-1] ? (ty == '0) : (ty < TW'(dim_h));

	always_ff @(posedge clk) begin
		res_s10.src_x    <= (ok_x && ok_y) ? tx[OUT_W-1:0] : '0;
		res_s10.src_y    <= (ok_x && ok_y) ? ty[OUT_W-1:0] : '0;
		res_s10.in_range <= ok_x && ok_y;
	end

	assign result = res_s10;

	// ---------------- assertions ----------------
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted transaction did not complete after the fixed latency");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching accepted transaction");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.in_range) |-> (result.src_x == '0 && result.src_y == '0))
		else $error("out-of-range result carries non-zero coordinates");

endmodule
